>>> src/mmse_fir_equalizer_unit_defines.svh
// ----------------------------------------------------------------------------
// MMSE FIR equalizer - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MMSE_FIR_EQUALIZER_UNIT_DEFINES_SVH
`define MMSE_FIR_EQUALIZER_UNIT_DEFINES_SVH

// Same-cycle implication
`define MEF_ASSERT_SAME(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication
`define MEF_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> src/mef_pkg.sv
// ----------------------------------------------------------------------------
// mef_pkg
// Types, widths, register codes and rounding helpers of the MMSE FIR equalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mef_pkg;

	localparam int EQ_TAPS_DEF    = 7;
	localparam int DROP_COUNT_DEF = 4;

	localparam int DATA_W    = 16;
	localparam int COEF_W    = 24;
	localparam int MAT_W     = 26;
	localparam int LAG_ACC_W = 34;
	localparam int DIV_W     = 56;
	localparam int QUO_W     = DIV_W + 1;
	localparam int FACC_W    = 44;
	localparam int CFG_IDX_W = 2;

	localparam int ELIM_LIMIT = 16777216;
	localparam int COEF_MAX   = 8388607;
	localparam int COEF_MIN   = -8388608;

	localparam logic [CFG_IDX_W-1:0] CFG_TAP_ZERO       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_ONE        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_TWO        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_VARIANCE = 2'd3;

	typedef struct packed {
		logic signed [DATA_W-1:0] tap_zero;
		logic signed [DATA_W-1:0] tap_one;
		logic signed [DATA_W-1:0] tap_two;
		logic        [DATA_W-1:0] noise_variance;
	} cfg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
		logic                     start;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
		logic                     failed;
	} res_t;

	typedef struct packed {
		logic done;
		logic failed;
	} solve_stat_t;

	// Shift right by 12, rounding half away from zero
	function automatic logic signed [MAT_W-1:0] round_shift12(
		input logic signed [LAG_ACC_W-1:0] v);
		logic                 neg;
		logic [LAG_ACC_W:0]   mag;
		logic [LAG_ACC_W:0]   rnd;
		logic signed [MAT_W-1:0] res;
		neg = v[LAG_ACC_W-1];
		mag = neg ? (LAG_ACC_W+1)'(-((LAG_ACC_W+1)'(v))) : (LAG_ACC_W+1)'(v);
		rnd = (mag + (LAG_ACC_W+1)'(2048)) >> 12;
		res = neg ? -$signed(rnd[MAT_W-1:0]) : $signed(rnd[MAT_W-1:0]);
		return res;
	endfunction

	// Shift right by 16, round half away from zero, saturate to 16 bit
	function automatic logic signed [DATA_W-1:0] sat_round16(
		input logic signed [FACC_W-1:0] v);
		logic              neg;
		logic [FACC_W:0]   mag;
		logic [FACC_W:0]   rnd;
		logic signed [DATA_W-1:0] res;
		neg = v[FACC_W-1];
		mag = neg ? (FACC_W+1)'(-((FACC_W+1)'(v))) : (FACC_W+1)'(v);
		rnd = (mag + (FACC_W+1)'(32768)) >> 16;
		if (!neg && rnd > (FACC_W+1)'(32767))
			res = 16'sh7FFF;
		else if (neg && rnd > (FACC_W+1)'(32767))
			res = 16'sh8000;
		else if (neg)
			res = -$signed(rnd[DATA_W-1:0]);
		else
			res = $signed(rnd[DATA_W-1:0]);
		return res;
	endfunction

	// Clamp an elimination result to [-2^24, 2^24]
	function automatic logic signed [MAT_W-1:0] clamp_elim(
		input logic signed [QUO_W:0] v);
		logic signed [MAT_W-1:0] res;
		if (v > $signed((QUO_W+1)'(ELIM_LIMIT)))
			res = MAT_W'(ELIM_LIMIT);
		else if (v < -$signed((QUO_W+1)'(ELIM_LIMIT)))
			res = -$signed(MAT_W'(ELIM_LIMIT));
		else
			res = v[MAT_W-1:0];
		return res;
	endfunction

	// Saturate a back-substitution quotient to Q8.16
	function automatic logic signed [COEF_W-1:0] clamp_coef(
		input logic signed [QUO_W-1:0] v);
		logic signed [COEF_W-1:0] res;
		if (v > $signed(QUO_W'(COEF_MAX)))
			res = COEF_W'(COEF_MAX);
		else if (v < $signed(QUO_W'(COEF_MIN)))
			res = COEF_W'(COEF_MIN);
		else
			res = v[COEF_W-1:0];
		return res;
	endfunction

endpackage

`default_nettype wire

>>> src/mmse_fir_equalizer_unit.sv
// ----------------------------------------------------------------------------
// mmse_fir_equalizer_unit
// 7-tap MMSE linear equalizer with on-chip coefficient solve per block.
// ----------------------------------------------------------------------------
// In the back end one shared 24x16 multiplier walks every tap, re and then
// im at each tap. A sample with block_start first runs the coefficient solve,
// paced by the bit-serial divider in each elimination update and each
// back-substitution step; the banded matrix keeps the number of elimination
// updates down. A two-word queue on each side lets input words and results
// wait without stalling the other side. The first DROP_COUNT samples after a
// block start give no result.
`default_nettype none

module mmse_fir_equalizer_unit #(
	parameter int EQ_TAPS    = mef_pkg::EQ_TAPS_DEF,
	parameter int DROP_COUNT = mef_pkg::DROP_COUNT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output      logic                                full,
	input  wire logic signed [mef_pkg::DATA_W-1:0]   sample_re,
	input  wire logic signed [mef_pkg::DATA_W-1:0]   sample_im,
	input  wire logic                                block_start,
	output      logic                                empty,
	input  wire logic                                pop,
	output      logic signed [mef_pkg::DATA_W-1:0]   out_re,
	output      logic signed [mef_pkg::DATA_W-1:0]   out_im,
	output      logic                                solve_failed,
	input  wire logic                                cfg_we,
	input  wire logic [mef_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [mef_pkg::DATA_W-1:0]          cfg_data
);

	import mef_pkg::*;

	cfg_t                     cfg_q;
	item_t                    in_word, in_item;
	res_t                     out_word, out_item;
	logic                     in_empty, in_pop;
	logic                     out_full, out_push;
	logic                     solve_go;
	solve_stat_t              stat;
	logic [$clog2(EQ_TAPS)-1:0] coef_idx;
	logic signed [COEF_W-1:0] coef;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_zero       <= 16'sd16384;
			cfg_q.tap_one        <= '0;
			cfg_q.tap_two        <= '0;
			cfg_q.noise_variance <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TAP_ZERO:       cfg_q.tap_zero       <= cfg_data;
				CFG_TAP_ONE:        cfg_q.tap_one        <= cfg_data;
				CFG_TAP_TWO:        cfg_q.tap_two        <= cfg_data;
				CFG_NOISE_VARIANCE: cfg_q.noise_variance <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: queue incoming words tagged with the block start
	assign in_word.re    = sample_re;
	assign in_word.im    = sample_im;
	assign in_word.start = block_start;

	mef_queue #(
		.WIDTH ($bits(item_t))
	) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (in_word),
		.full   (full),
		.pop    (in_pop),
		.dout   (in_item),
		.empty  (in_empty)
	);

	mef_solver #(
		.EQ_TAPS (EQ_TAPS)
	) u_solver (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.go       (solve_go),
		.stat     (stat),
		.coef_idx (coef_idx),
		.coef     (coef)
	);

	mef_filter #(
		.EQ_TAPS    (EQ_TAPS),
		.DROP_COUNT (DROP_COUNT)
	) u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_empty (in_empty),
		.in_item  (in_item),
		.in_pop   (in_pop),
		.out_full (out_full),
		.out_item (out_word),
		.out_push (out_push),
		.solve_go (solve_go),
		.stat     (stat),
		.coef_idx (coef_idx),
		.coef     (coef)
	);

	mef_queue #(
		.WIDTH ($bits(res_t))
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (out_word),
		.full   (out_full),
		.pop    (pop),
		.dout   (out_item),
		.empty  (empty)
	);

	assign out_re       = out_item.re;
	assign out_im       = out_item.im;
	assign solve_failed = out_item.failed;

endmodule

`default_nettype wire

>>> src/mef_ram.sv
// ----------------------------------------------------------------------------
// mef_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mef_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output      logic [WIDTH-1:0]         rd_data_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output      logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

`default_nettype wire

>>> src/mef_queue.sv
// ----------------------------------------------------------------------------
// mef_queue
// Two-word queue between the sides of the equalizer.
// ----------------------------------------------------------------------------
`default_nettype none

module mef_queue #(
	parameter int WIDTH = 33
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output      logic             full,
	input  wire logic             pop,
	output      logic [WIDTH-1:0] dout,
	output      logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign dout    = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Store pushed word
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= din;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/mef_solver.sv
// ----------------------------------------------------------------------------
// mef_solver
// Coefficient solver: builds (R + nv*I | d) in a RAM, runs Gaussian elimination
// and back substitution with one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mef_solver #(
	parameter int EQ_TAPS = mef_pkg::EQ_TAPS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire mef_pkg::cfg_t                      cfg,
	input  wire logic                               go,
	output      mef_pkg::solve_stat_t               stat,
	input  wire logic [$clog2(EQ_TAPS)-1:0]         coef_idx,
	output      logic signed [mef_pkg::COEF_W-1:0]  coef
);

	import mef_pkg::*;

	localparam int RW    = $clog2(EQ_TAPS);
	localparam int CW    = $clog2(EQ_TAPS + 1);
	localparam int AW    = RW + CW;
	localparam int PAD   = (EQ_TAPS - 3) / 2;
	localparam int DCW   = $clog2(DIV_W + 1);
	localparam logic [RW-1:0] LAST_ROW = RW'(EQ_TAPS - 1);
	localparam logic [CW-1:0] RHS_COL  = CW'(EQ_TAPS);

	typedef enum logic [19:0] {
		S_IDLE    = 20'd1,
		S_LAG     = 20'd2,
		S_INIT    = 20'd4,
		S_PIV_RD  = 20'd8,
		S_PIV     = 20'd16,
		S_F_RD    = 20'd32,
		S_F       = 20'd64,
		S_UPD_RD  = 20'd128,
		S_UPD_MUL = 20'd256,
		S_UPD_GO  = 20'd512,
		S_UPD_DIV = 20'd1024,
		S_UPD_WR  = 20'd2048,
		S_BS_RD   = 20'd4096,
		S_BS_LD   = 20'd8192,
		S_BS_MRD  = 20'd16384,
		S_BS_MUL  = 20'd32768,
		S_BS_ACC  = 20'd65536,
		S_BS_GO   = 20'd131072,
		S_BS_DIV  = 20'd262144,
		S_DONE    = 20'd524288
	} sol_state_t;

	sol_state_t                  state_q;
	logic [2:0]                  lag_cnt_q;
	logic signed [LAG_ACC_W-1:0] r0_q, r1_q, r2_q;
	logic [RW-1:0]               p_q, i_q;
	logic [CW-1:0]               k_q;
	logic signed [MAT_W-1:0]     f_q, aik_q;
	logic [MAT_W-1:0]            piv_q, diag_q, dvs_q, rem_q;
	logic signed [2*MAT_W-1:0]   prod_q;
	logic signed [DIV_W-1:0]     acc_q;
	logic [DIV_W-1:0]            quo_q;
	logic                        neg_q;
	logic [DCW-1:0]              dcnt_q;
	logic                        sing_q;
	logic signed [COEF_W-1:0]    x_q [EQ_TAPS];

	logic signed [DATA_W-1:0]    mul_a, mul_b;
	logic signed [MAT_W-1:0]     lag0, lag1, lag2, init_val;
	logic [CW-1:0]               ic, lag_dist;
	logic signed [MAT_W-1:0]     m_a, m_b;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr, rd_addr_a, rd_addr_b;
	logic signed [MAT_W-1:0]     wr_data, rd_a, rd_b;
	logic [MAT_W:0]              rem_sh;
	logic                        ge;
	logic signed [QUO_W-1:0]     q_s;
	logic signed [DIV_W-1:0]     dvd;

	assign stat.done   = (state_q == S_DONE);
	assign stat.failed = sing_q;
	assign coef        = x_q[coef_idx];

	// Select lag product operands
	always_comb begin
		case (lag_cnt_q)
			3'd0: begin mul_a = cfg.tap_zero; mul_b = cfg.tap_zero; end
			3'd1: begin mul_a = cfg.tap_one;  mul_b = cfg.tap_one;  end
			3'd2: begin mul_a = cfg.tap_two;  mul_b = cfg.tap_two;  end
			3'd3: begin mul_a = cfg.tap_zero; mul_b = cfg.tap_one;  end
			3'd4: begin mul_a = cfg.tap_one;  mul_b = cfg.tap_two;  end
			default: begin mul_a = cfg.tap_zero; mul_b = cfg.tap_two; end
		endcase
	end

	assign lag0 = round_shift12(r0_q);
	assign lag1 = round_shift12(r1_q);
	assign lag2 = round_shift12(r2_q);

	// Build the augmented matrix entry at row i, column k
	always_comb begin
		ic       = CW'(i_q);
		lag_dist = (ic > k_q) ? (ic - k_q) : (k_q - ic);
		if (k_q == RHS_COL) begin
			if (i_q == RW'(PAD))
				init_val = MAT_W'($signed({cfg.tap_two, 2'b00}));
			else if (i_q == RW'(PAD + 1))
				init_val = MAT_W'($signed({cfg.tap_one, 2'b00}));
			else if (i_q == RW'(PAD + 2))
				init_val = MAT_W'($signed({cfg.tap_zero, 2'b00}));
			else
				init_val = '0;
		end else if (lag_dist == CW'(0)) begin
			init_val = lag0 + $signed(MAT_W'({cfg.noise_variance, 2'b00}));
		end else if (lag_dist == CW'(1)) begin
			init_val = lag1;
		end else if (lag_dist == CW'(2)) begin
			init_val = lag2;
		end else begin
			init_val = '0;
		end
	end

	// Shared multiplier operands
	assign m_a = (state_q == S_BS_MUL) ? rd_a : f_q;
	assign m_b = (state_q == S_BS_MUL) ? MAT_W'(x_q[k_q[RW-1:0]]) : rd_a;

	// Divider step and signed quotient
	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign ge     = (rem_sh >= {1'b0, dvs_q});
	assign q_s    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign dvd    = (state_q == S_UPD_GO) ? DIV_W'(prod_q) : acc_q;

	// Matrix RAM port addressing
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = {i_q, k_q};
		wr_data   = init_val;
		rd_addr_a = '0;
		rd_addr_b = '0;
		case (state_q)
			S_INIT: begin
				wr_en = 1'b1;
			end
			S_UPD_WR: begin
				wr_en   = 1'b1;
				wr_data = clamp_elim((QUO_W+1)'(aik_q) - (QUO_W+1)'(q_s));
			end
			S_PIV_RD: rd_addr_a = {p_q, CW'(p_q)};
			S_F_RD:   rd_addr_a = {i_q, CW'(p_q)};
			S_UPD_RD: begin
				rd_addr_a = {p_q, k_q};
				rd_addr_b = {i_q, k_q};
			end
			S_BS_RD: begin
				rd_addr_a = {i_q, RHS_COL};
				rd_addr_b = {i_q, CW'(i_q)};
			end
			S_BS_MRD: rd_addr_a = {i_q, k_q};
			default: ;
		endcase
	end

	mef_ram #(
		.WIDTH (MAT_W),
		.DEPTH (2 ** AW)
	) u_mat (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_b)
	);

	// Solve sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			lag_cnt_q <= '0;
			r0_q      <= '0;
			r1_q      <= '0;
			r2_q      <= '0;
			p_q       <= '0;
			i_q       <= '0;
			k_q       <= '0;
			dcnt_q    <= '0;
			sing_q    <= 1'b0;
			for (int n = 0; n < EQ_TAPS; n++) begin
				x_q[n] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (go) begin
						lag_cnt_q <= '0;
						r0_q      <= '0;
						r1_q      <= '0;
						r2_q      <= '0;
						sing_q    <= 1'b0;
						state_q   <= S_LAG;
					end
				end
				// Accumulate the three lags, one product a cycle
				S_LAG: begin
					case (lag_cnt_q)
						3'd0, 3'd1, 3'd2: r0_q <= r0_q + LAG_ACC_W'(mul_a * mul_b);
						3'd3, 3'd4:       r1_q <= r1_q + LAG_ACC_W'(mul_a * mul_b);
						default:          r2_q <= r2_q + LAG_ACC_W'(mul_a * mul_b);
					endcase
					lag_cnt_q <= lag_cnt_q + 3'd1;
					if (lag_cnt_q == 3'd5) begin
						i_q     <= '0;
						k_q     <= '0;
						state_q <= S_INIT;
					end
				end
				// Fill the matrix one entry a cycle
				S_INIT: begin
					if (k_q == RHS_COL) begin
						k_q <= '0;
						if (i_q == LAST_ROW) begin
							p_q     <= '0;
							state_q <= S_PIV_RD;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_PIV_RD: state_q <= S_PIV;
				// Check pivot (a non-positive one fails the solve), drop to back substitution after the last one
				S_PIV: begin
					piv_q <= rd_a;
					if (rd_a[MAT_W-1] || rd_a == '0) begin
						sing_q <= 1'b1;
						for (int n = 0; n < EQ_TAPS; n++) begin
							x_q[n] <= '0;
						end
						state_q <= S_DONE;
					end else if (p_q == LAST_ROW) begin
						i_q     <= LAST_ROW;
						state_q <= S_BS_RD;
					end else begin
						i_q     <= p_q + 1'b1;
						state_q <= S_F_RD;
					end
				end
				S_F_RD: state_q <= S_F;
				// Skip rows with a zero factor
				S_F: begin
					f_q <= rd_a;
					if (rd_a == '0) begin
						if (i_q == LAST_ROW) begin
							p_q     <= p_q + 1'b1;
							state_q <= S_PIV_RD;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_F_RD;
						end
					end else begin
						k_q     <= CW'(p_q) + 1'b1;
						state_q <= S_UPD_RD;
					end
				end
				S_UPD_RD: state_q <= S_UPD_MUL;
				S_UPD_MUL: begin
					prod_q  <= m_a * m_b;
					aik_q   <= rd_b;
					state_q <= S_UPD_GO;
				end
				S_UPD_GO, S_BS_GO: begin
					dvs_q   <= (state_q == S_UPD_GO) ? piv_q : diag_q;
					neg_q   <= dvd[DIV_W-1];
					quo_q   <= dvd[DIV_W-1] ? DIV_W'(-dvd) : DIV_W'(dvd);
					rem_q   <= '0;
					dcnt_q  <= DCW'(DIV_W);
					state_q <= (state_q == S_UPD_GO) ? S_UPD_DIV : S_BS_DIV;
				end
				S_UPD_DIV: begin
					if (dcnt_q != '0) begin
						rem_q  <= ge ? MAT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[MAT_W-1:0];
						quo_q  <= {quo_q[DIV_W-2:0], ge};
						dcnt_q <= dcnt_q - 1'b1;
					end else begin
						state_q <= S_UPD_WR;
					end
				end
				// Entry written by the port logic; advance column, row, pivot
				S_UPD_WR: begin
					if (k_q == RHS_COL) begin
						if (i_q == LAST_ROW) begin
							p_q     <= p_q + 1'b1;
							state_q <= S_PIV_RD;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_F_RD;
						end
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_UPD_RD;
					end
				end
				S_BS_RD: state_q <= S_BS_LD;
				S_BS_LD: begin
					acc_q  <= DIV_W'(rd_a) <<< 16;
					diag_q <= rd_b;
					if (i_q == LAST_ROW) begin
						state_q <= S_BS_GO;
					end else begin
						k_q     <= CW'(i_q) + 1'b1;
						state_q <= S_BS_MRD;
					end
				end
				S_BS_MRD: state_q <= S_BS_MUL;
				S_BS_MUL: begin
					prod_q  <= m_a * m_b;
					state_q <= S_BS_ACC;
				end
				S_BS_ACC: begin
					acc_q <= acc_q - DIV_W'(prod_q);
					if (k_q == CW'(LAST_ROW)) begin
						state_q <= S_BS_GO;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_BS_MRD;
					end
				end
				S_BS_DIV: begin
					if (dcnt_q != '0) begin
						rem_q  <= ge ? MAT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[MAT_W-1:0];
						quo_q  <= {quo_q[DIV_W-2:0], ge};
						dcnt_q <= dcnt_q - 1'b1;
					end else begin
						x_q[i_q] <= clamp_coef(q_s);
						if (i_q == '0) begin
							state_q <= S_DONE;
						end else begin
							i_q     <= i_q - 1'b1;
							state_q <= S_BS_RD;
						end
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/mef_filter.sv
// ----------------------------------------------------------------------------
// mef_filter
// Back end: takes a word from the input queue, runs the solve on a block start,
// filters re and im through the tap line with one multiplier, drops the first
// outputs of a block and pushes the rest to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mmse_fir_equalizer_unit_defines.svh"

module mef_filter #(
	parameter int EQ_TAPS    = mef_pkg::EQ_TAPS_DEF,
	parameter int DROP_COUNT = mef_pkg::DROP_COUNT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_empty,
	input  wire mef_pkg::item_t                    in_item,
	output      logic                              in_pop,
	input  wire logic                              out_full,
	output      mef_pkg::res_t                     out_item,
	output      logic                              out_push,
	output      logic                              solve_go,
	input  wire mef_pkg::solve_stat_t              stat,
	output      logic [$clog2(EQ_TAPS)-1:0]        coef_idx,
	input  wire logic signed [mef_pkg::COEF_W-1:0] coef
);

	import mef_pkg::*;

	localparam int RW  = $clog2(EQ_TAPS);
	localparam int DIW = $clog2(EQ_TAPS - 1);
	localparam int SW  = $clog2(DROP_COUNT + 2);
	localparam logic [RW-1:0] LAST_TAP = RW'(EQ_TAPS - 1);
	localparam logic [SW-1:0] DROP_LIM = SW'(DROP_COUNT);

	typedef enum logic [5:0] {
		F_IDLE  = 6'b000001,
		F_SOLVE = 6'b000010,
		F_MUL   = 6'b000100,
		F_ACC   = 6'b001000,
		F_OUT   = 6'b010000,
		F_PUSH  = 6'b100000
	} flt_state_t;

	flt_state_t                        state_q;
	item_t                             cur_q;
	res_t                              res_q;
	logic [RW-1:0]                     t_q;
	logic                              lane_q;
	logic [SW-1:0]                     seen_q;
	logic signed [DATA_W-1:0]          dre_q [EQ_TAPS-1];
	logic signed [DATA_W-1:0]          dim_q [EQ_TAPS-1];
	logic signed [COEF_W+DATA_W-1:0]   prod_s1;
	logic signed [FACC_W-1:0]          acc_re_q, acc_im_q;
	logic [RW-1:0]                     dix;
	logic signed [DATA_W-1:0]          smp;

	assign in_pop   = (state_q == F_IDLE) && !in_empty;
	assign out_push = (state_q == F_PUSH) && !out_full;
	assign solve_go = in_pop && in_item.start;
	assign out_item = res_q;
	assign coef_idx = t_q;

	// Pick the sample for the current tap and lane
	always_comb begin
		dix = t_q - 1'b1;
		if (t_q == '0)
			smp = lane_q ? cur_q.im : cur_q.re;
		else
			smp = lane_q ? dim_q[dix[DIW-1:0]] : dre_q[dix[DIW-1:0]];
	end

	// Product register and lane accumulators
	always_ff @(posedge clk) begin
		if (state_q == F_MUL) begin
			prod_s1 <= coef * smp;
		end
		if (in_pop) begin
			cur_q    <= in_item;
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (state_q == F_ACC) begin
			if (lane_q)
				acc_im_q <= acc_im_q + FACC_W'(prod_s1);
			else
				acc_re_q <= acc_re_q + FACC_W'(prod_s1);
		end
		if (state_q == F_OUT) begin
			res_q.re     <= sat_round16(acc_re_q);
			res_q.im     <= sat_round16(acc_im_q);
			res_q.failed <= stat.failed;
		end
	end

	// Sequence one word: solve, multiply-accumulate, drop or push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			t_q     <= '0;
			lane_q  <= 1'b0;
			seen_q  <= '0;
			for (int n = 0; n < EQ_TAPS - 1; n++) begin
				dre_q[n] <= '0;
				dim_q[n] <= '0;
			end
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_pop) begin
						t_q    <= '0;
						lane_q <= 1'b0;
						if (in_item.start) begin
							seen_q <= '0;
							for (int n = 0; n < EQ_TAPS - 1; n++) begin
								dre_q[n] <= '0;
								dim_q[n] <= '0;
							end
							state_q <= F_SOLVE;
						end else begin
							state_q <= F_MUL;
						end
					end
				end
				F_SOLVE: begin
					if (stat.done) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: state_q <= F_ACC;
				F_ACC: begin
					if (lane_q) begin
						lane_q <= 1'b0;
						if (t_q == LAST_TAP) begin
							state_q <= F_OUT;
						end else begin
							t_q     <= t_q + 1'b1;
							state_q <= F_MUL;
						end
					end else begin
						lane_q  <= 1'b1;
						state_q <= F_MUL;
					end
				end
				// Shift the tap line, count drops
				F_OUT: begin
					dre_q[0] <= cur_q.re;
					dim_q[0] <= cur_q.im;
					for (int n = 1; n < EQ_TAPS - 1; n++) begin
						dre_q[n] <= dre_q[n-1];
						dim_q[n] <= dim_q[n-1];
					end
					if (seen_q < DROP_LIM) begin
						seen_q  <= seen_q + 1'b1;
						state_q <= F_IDLE;
					end else begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!out_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	`MEF_ASSERT_SAME(a_pop_has_word, in_pop, !in_empty, "pop from empty input queue")
	`MEF_ASSERT_SAME(a_push_has_room, out_push, !out_full, "push into full result queue")
	`MEF_ASSERT_NEXT(a_go_waits_solve, solve_go, state_q == F_SOLVE, "solve start not awaited")
	`MEF_ASSERT_SAME(a_seen_bounded, 1'b1, seen_q <= DROP_LIM, "drop counter past limit")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the MMSE FIR equalizer. It runs its own fixed-point model of
// the coefficient solve and the seven-tap filter next to the block. Each
// result word is checked field by field against the oldest expected word.
// Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import mef_pkg::*;

	localparam int NTAPS     = EQ_TAPS_DEF;
	localparam int NDROP     = DROP_COUNT_DEF;
	localparam int SETTLE    = 12000;
	localparam int CLK_HALF  = 6;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	logic signed [DATA_W-1:0] sample_re = '0;
	logic signed [DATA_W-1:0] sample_im = '0;
	logic                     block_start = 1'b0;
	logic                     empty;
	logic                     pop = 1'b0;
	logic signed [DATA_W-1:0] out_re;
	logic signed [DATA_W-1:0] out_im;
	logic                     solve_failed;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [DATA_W-1:0]        cfg_data = '0;

	mmse_fir_equalizer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample_re    (sample_re),
		.sample_im    (sample_im),
		.block_start  (block_start),
		.empty        (empty),
		.pop          (pop),
		.out_re       (out_re),
		.out_im       (out_im),
		.solve_failed (solve_failed),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Model state
	cfg_t    shadow_cfg;
	longint  eq_coef [NTAPS];
	longint  hist_re [NTAPS-1];
	longint  hist_im [NTAPS-1];
	int      drop_cnt;
	bit      singular;

	res_t    pending_words [$];
	int      error_count;
	int      sent_count;
	int      checked_count;
	int      block_count;
	int      singular_blocks;
	int      burst_left;

	// Clock
	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// Watchdog
	initial begin
		#(64'd12 * 64'd3000000);
		$display("TEST FAILED");
		$finish;
	end

	function automatic longint round_off(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Solve (R + nv*I) c = d for the current channel taps
	function automatic void solve_coefficients();
		longint a [NTAPS][NTAPS];
		longint b [NTAPS];
		longint x [NTAPS];
		longint lag [3];
		longint h0, h1, h2, piv, f, acc;
		int     d, pad;
		h0 = longint'(shadow_cfg.tap_zero);
		h1 = longint'(shadow_cfg.tap_one);
		h2 = longint'(shadow_cfg.tap_two);
		pad = (NTAPS - 3) / 2;
		lag[0] = round_off(h0 * h0 + h1 * h1 + h2 * h2, 12);
		lag[1] = round_off(h0 * h1 + h1 * h2, 12);
		lag[2] = round_off(h0 * h2, 12);
		for (int i = 0; i < NTAPS; i++) begin
			for (int k = 0; k < NTAPS; k++) begin
				d = (i > k) ? i - k : k - i;
				a[i][k] = (d <= 2) ? lag[d] : 0;
			end
			a[i][i] += longint'(shadow_cfg.noise_variance) * 4;
			b[i] = 0;
		end
		b[pad]     = h2 * 4;
		b[pad + 1] = h1 * 4;
		b[pad + 2] = h0 * 4;
		singular = 1'b0;
		// Forward elimination, no pivoting
		for (int p = 0; p < NTAPS && !singular; p++) begin
			piv = a[p][p];
			if (piv <= 0) begin
				singular = 1'b1;
			end else begin
				for (int i = p + 1; i < NTAPS; i++) begin
					f = a[i][p];
					a[i][p] = 0;
					if (f != 0) begin
						for (int k = p + 1; k < NTAPS; k++)
							a[i][k] = clip(a[i][k] - (f * a[p][k]) / piv,
								-ELIM_LIMIT, ELIM_LIMIT);
						b[i] = clip(b[i] - (f * b[p]) / piv, -ELIM_LIMIT, ELIM_LIMIT);
					end
				end
			end
		end
		if (singular) begin
			foreach (eq_coef[i]) eq_coef[i] = 0;
			return;
		end
		// Back substitution into Q8.16
		for (int i = NTAPS - 1; i >= 0; i--) begin
			acc = b[i] * 65536;
			for (int k = i + 1; k < NTAPS; k++)
				acc -= a[i][k] * x[k];
			x[i] = clip(acc / a[i][i], COEF_MIN, COEF_MAX);
		end
		foreach (eq_coef[i]) eq_coef[i] = x[i];
	endfunction

	function automatic longint fir_out(longint cur, longint line [NTAPS-1]);
		longint acc;
		acc = eq_coef[0] * cur;
		for (int k = 1; k < NTAPS; k++)
			acc += eq_coef[k] * line[k-1];
		return clip(round_off(acc, 16), -32768, 32767);
	endfunction

	// Advance the model by one accepted sample
	function automatic void equalize_sample(logic signed [DATA_W-1:0] re,
		logic signed [DATA_W-1:0] im, logic start);
		res_t   w;
		longint yr, yi;
		if (start) begin
			solve_coefficients();
			foreach (hist_re[i]) begin
				hist_re[i] = 0;
				hist_im[i] = 0;
			end
			drop_cnt = 0;
			block_count++;
			if (singular) singular_blocks++;
		end
		yr = fir_out(longint'(re), hist_re);
		yi = fir_out(longint'(im), hist_im);
		for (int k = NTAPS - 2; k > 0; k--) begin
			hist_re[k] = hist_re[k-1];
			hist_im[k] = hist_im[k-1];
		end
		hist_re[0] = longint'(re);
		hist_im[0] = longint'(im);
		if (drop_cnt < NDROP) begin
			drop_cnt++;
		end else begin
			w.re     = DATA_W'(yr);
			w.im     = DATA_W'(yi);
			w.failed = singular;
			pending_words.push_back(w);
		end
	endfunction

	// Send one sample; push stays high across a burst
	task automatic send_sample(logic signed [DATA_W-1:0] re,
		logic signed [DATA_W-1:0] im, logic start);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		burst_left--;
		push        <= 1'b1;
		sample_re   <= re;
		sample_im   <= im;
		block_start <= start;
		do @(posedge clk); while (full);
		equalize_sample(re, im, start);
		sent_count++;
	endtask

	// Drop push and wait until the block has drained
	task automatic drain();
		push <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_words.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges
	task automatic load_config(logic [DATA_W-1:0] t0, logic [DATA_W-1:0] t1,
		logic [DATA_W-1:0] t2, logic [DATA_W-1:0] nv);
		logic [DATA_W-1:0] vals [4];
		logic [CFG_IDX_W-1:0] idx [4];
		vals = '{t0, t1, t2, nv};
		idx  = '{CFG_TAP_ZERO, CFG_TAP_ONE, CFG_TAP_TWO, CFG_NOISE_VARIANCE};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			case (idx[i])
				CFG_TAP_ZERO:       shadow_cfg.tap_zero = vals[i];
				CFG_TAP_ONE:        shadow_cfg.tap_one = vals[i];
				CFG_TAP_TWO:        shadow_cfg.tap_two = vals[i];
				CFG_NOISE_VARIANCE: shadow_cfg.noise_variance = vals[i];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [DATA_W-1:0] pick_sample();
		logic signed [DATA_W-1:0] edges [4];
		edges = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
		if ($urandom_range(0, 9) == 0)
			return edges[$urandom_range(0, 3)];
		return DATA_W'($urandom);
	endfunction

	// Reset defaults: zero coefficients before any block, then a unit channel
	task automatic test_power_on();
		for (int i = 0; i < 6; i++)
			send_sample(16'sh7FFF, 16'sh8000, 1'b0);
		send_sample(16'sh4000, -16'sh4000, 1'b1);
		send_sample(16'sh7FFF, 16'sh8000, 1'b0);
		send_sample(16'sh8000, 16'sh7FFF, 1'b0);
		send_sample(16'sh0001, 16'shFFFF, 1'b0);
		send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 16'sh8000, 1'b0);
		drain();
	endtask

	// Extreme taps and noise: heavy saturation in solve and filter
	task automatic test_extremes();
		load_config(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
		send_sample(16'sh7FFF, 16'sh8000, 1'b1);
		for (int i = 0; i < 6; i++)
			send_sample((i % 2) ? 16'sh8000 : 16'sh7FFF, (i % 2) ? 16'sh7FFF : 16'sh8000, 1'b0);
		drain();
	endtask

	// All-zero channel: singular solve; also blocks shorter than the drop count
	task automatic test_singular();
		load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'sh1234, 16'sh8000, 1'b1);
		send_sample(16'sh7FFF, 16'sh0000, 1'b1);
		for (int i = 0; i < 5; i++)
			send_sample(16'sh7FFF, 16'sh8000, 1'b0);
		drain();
	endtask

	// Extreme, then random settings, mostly well-formed blocks with random content
	task automatic test_random(int total);
		int phases, per_phase, len, done;
		logic [DATA_W-1:0] t0, t1, t2, nv;
		phases = 10;
		per_phase = total / phases;
		for (int ph = 0; ph < phases; ph++) begin
			case (ph)
				0: begin t0 = 16'h8000; t1 = 16'h8000; t2 = 16'h8000; nv = 16'h0000; end
				1: begin t0 = 16'h7FFF; t1 = 16'h7FFF; t2 = 16'h7FFF; nv = 16'hFFFF; end
				default: begin
					if ($urandom_range(0, 1)) begin
						t0 = DATA_W'($urandom_range(8192, 24576));
						t1 = DATA_W'($signed($urandom_range(0, 16384)) - 8192);
						t2 = DATA_W'($signed($urandom_range(0, 8192)) - 4096);
						nv = DATA_W'($urandom_range(0, 4096));
					end else begin
						t0 = DATA_W'($urandom);
						t1 = DATA_W'($urandom);
						t2 = DATA_W'($urandom);
						nv = DATA_W'($urandom);
					end
				end
			endcase
			load_config(t0, t1, t2, nv);
			done = 0;
			while (done < per_phase) begin
				len = ($urandom_range(0, 6) == 0) ? $urandom_range(1, NDROP)
					: $urandom_range(NDROP + 1, 60);
				// a stray sample without block start now and then
				send_sample(pick_sample(), pick_sample(), ($urandom_range(0, 19) != 0));
				for (int i = 1; i < len; i++)
					send_sample(pick_sample(), pick_sample(), 1'b0);
				done += len;
			end
			drain();
		end
	endtask

	// Receiver: checks each popped word; stall patterns change over time
	initial begin
		res_t exp_w;
		int   mode, tick;
		mode = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (pending_words.size() == 0) begin
					$error("result word with nothing expected: re=%0d im=%0d failed=%0b",
						out_re, out_im, solve_failed);
					error_count++;
				end else begin
					exp_w = pending_words.pop_front();
					checked_count++;
					if (out_re !== exp_w.re) begin
						$error("out_re expected %0d actual %0d", exp_w.re, out_re);
						error_count++;
					end
					if (out_im !== exp_w.im) begin
						$error("out_im expected %0d actual %0d", exp_w.im, out_im);
						error_count++;
					end
					if (solve_failed !== exp_w.failed) begin
						$error("solve_failed expected %0b actual %0b", exp_w.failed,
							solve_failed);
						error_count++;
					end
				end
			end
			tick++;
			if (tick % 64 == 0) mode = $urandom_range(0, 3);
			case (mode)
				0: pop <= 1'b1;
				1: pop <= $urandom_range(0, 1);
				2: pop <= (tick % 4 == 0);
				default: pop <= ((tick % 64) > 48);
			endcase
		end
	end

	// Test sequence
	initial begin
		shadow_cfg = '{tap_zero: 16'sd16384, tap_one: '0, tap_two: '0, noise_variance: '0};
		foreach (eq_coef[i]) eq_coef[i] = 0;
		foreach (hist_re[i]) begin
			hist_re[i] = 0;
			hist_im[i] = 0;
		end
		drop_cnt = 0;
		singular = 1'b0;
		error_count = 0;
		sent_count = 0;
		checked_count = 0;
		block_count = 0;
		singular_blocks = 0;
		burst_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on();
		test_extremes();
		test_singular();
		test_random(1380);
		repeat (200) @(posedge clk);

		$display("Sent %0d samples in %0d blocks (%0d singular), checked %0d words.",
			sent_count, block_count, singular_blocks, checked_count);
		if (error_count == 0 && pending_words.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
